// ===== hdl/random_sample_without_replacement_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the random sample unit
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef RANDOM_SAMPLE_WITHOUT_REPLACEMENT_UNIT_ASSERT_SVH
`define RANDOM_SAMPLE_WITHOUT_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define RSWR_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define RSWR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/rswr_pkg.sv =====
// ---------------------------------------------------------------------------
// rswr_pkg
// Shared constants, codes and control structs of the random sample unit.
// ---------------------------------------------------------------------------
package rswr_pkg;

    localparam int MAX_POSITIONS = 65536;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int TAG_W         = 8;
    localparam int RAM_W         = ADDR_W + TAG_W;
    localparam int CFG_W         = 17;
    localparam int SEED_W        = 32;
    localparam int OUT_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_CLIP      = (MAX_POSITIONS < (2 ** CFG_W)) ?
                                   MAX_POSITIONS : (2 ** CFG_W) - 1;

    localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
    localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd42;

    localparam logic [CFG_W-1:0] COUNT_RESET = 17'd65536;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 17'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_COUNT = 2'd0,
        REG_SAMPLE_LIMIT   = 2'd1,
        REG_SEED           = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_ADV,
        OP_DLD,
        OP_DIV,
        OP_RDA,
        OP_RDB,
        OP_WRA,
        OP_WRB,
        OP_EXH,
        OP_RST
    } op_t;

    typedef struct packed {
        op_t  op;
        logic idle;
    } ctl_t;

    typedef struct packed {
        logic exhausted;
        logic div_last;
        logic clr_last;
        logic epoch_max;
    } sts_t;

endpackage

// ===== hdl/rswr_ram.sv =====
// ---------------------------------------------------------------------------
// rswr_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module rswr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/rswr_seq.sv =====
// ---------------------------------------------------------------------------
// rswr_seq
// Microcode sequencer: step counter, control ROM and jump conditions.
// ---------------------------------------------------------------------------
module rswr_seq import rswr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic accept,
    input  logic restart,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JMP,
        C_WAIT_IN,
        C_LOOP_CLR,
        C_LOOP_DIV,
        C_IF_EXH,
        C_IF_WRAP
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] UPC_CLEAR = 4'd0;
    localparam logic [PC_W-1:0] UPC_IDLE  = 4'd1;
    localparam logic [PC_W-1:0] UPC_CHK   = 4'd2;
    localparam logic [PC_W-1:0] UPC_ADV   = 4'd3;
    localparam logic [PC_W-1:0] UPC_DLD   = 4'd4;
    localparam logic [PC_W-1:0] UPC_DIV   = 4'd5;
    localparam logic [PC_W-1:0] UPC_RDA   = 4'd6;
    localparam logic [PC_W-1:0] UPC_RDB   = 4'd7;
    localparam logic [PC_W-1:0] UPC_WRA   = 4'd8;
    localparam logic [PC_W-1:0] UPC_WRB   = 4'd9;
    localparam logic [PC_W-1:0] UPC_EXH   = 4'd10;
    localparam logic [PC_W-1:0] UPC_RST   = 4'd11;

    function automatic uword_t rom(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            UPC_CLEAR: w = '{op: OP_CLR,  cond: C_LOOP_CLR, target: UPC_CLEAR};
            UPC_IDLE:  w = '{op: OP_NONE, cond: C_WAIT_IN,  target: UPC_RST};
            UPC_CHK:   w = '{op: OP_NONE, cond: C_IF_EXH,   target: UPC_EXH};
            UPC_ADV:   w = '{op: OP_ADV,  cond: C_NEXT,     target: UPC_IDLE};
            UPC_DLD:   w = '{op: OP_DLD,  cond: C_NEXT,     target: UPC_IDLE};
            UPC_DIV:   w = '{op: OP_DIV,  cond: C_LOOP_DIV, target: UPC_DIV};
            UPC_RDA:   w = '{op: OP_RDA,  cond: C_NEXT,     target: UPC_IDLE};
            UPC_RDB:   w = '{op: OP_RDB,  cond: C_NEXT,     target: UPC_IDLE};
            UPC_WRA:   w = '{op: OP_WRA,  cond: C_NEXT,     target: UPC_IDLE};
            UPC_WRB:   w = '{op: OP_WRB,  cond: C_JMP,      target: UPC_IDLE};
            UPC_EXH:   w = '{op: OP_EXH,  cond: C_JMP,      target: UPC_IDLE};
            UPC_RST:   w = '{op: OP_RST,  cond: C_IF_WRAP,  target: UPC_CLEAR};
            default:   w = '{op: OP_NONE, cond: C_JMP,      target: UPC_IDLE};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;
    uword_t          uw;

    assign uw     = rom(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    always_comb begin
        case (uw.cond)
            C_NEXT:     pc_next = pc_inc;
            C_JMP:      pc_next = uw.target;
            C_WAIT_IN:  pc_next = !accept ? pc_reg : (restart ? uw.target : pc_inc);
            C_LOOP_CLR: pc_next = sts.clr_last ? pc_inc : uw.target;
            C_LOOP_DIV: pc_next = sts.div_last ? pc_inc : uw.target;
            C_IF_EXH:   pc_next = sts.exhausted ? uw.target : pc_inc;
            C_IF_WRAP:  pc_next = sts.epoch_max ? uw.target : UPC_IDLE;
            default:    pc_next = UPC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UPC_CLEAR;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctl.op   = uw.op;
    assign ctl.idle = (pc_reg == UPC_IDLE);

endmodule

// ===== hdl/rswr_datapath.sv =====
// ---------------------------------------------------------------------------
// rswr_datapath
// Generator, remainder divider, tagged pool memory and result register.
// ---------------------------------------------------------------------------
module rswr_datapath import rswr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctl_t              ctl,
    input  logic [CFG_W-1:0]  position_count,
    input  logic [CFG_W-1:0]  sample_limit,
    input  logic [SEED_W-1:0] seed,
    input  logic              m_ready,
    output sts_t              sts,
    output logic              m_valid,
    output logic [OUT_W-1:0]  m_index,
    output logic [OUT_W-1:0]  m_draw_number,
    output logic              m_exhausted
);

    localparam int DIV_BITS = SEED_W - 1;
    localparam int CNT_W    = $clog2(DIV_BITS);

    function automatic logic [ADDR_W-1:0] pool_value(
        input logic [RAM_W-1:0]  entry,
        input logic [ADDR_W-1:0] addr,
        input logic [TAG_W-1:0]  tag
    );
        return (entry[RAM_W-1 -: TAG_W] == tag) ? entry[ADDR_W-1:0] : addr;
    endfunction

    logic [SEED_W-1:0]   gen_reg,   gen_next;
    logic [CFG_W-1:0]    step_reg,  step_next;
    logic [TAG_W-1:0]    epoch_reg, epoch_next;
    logic [ADDR_W-1:0]   clr_reg,   clr_next;
    logic [CFG_W-1:0]    d_reg,     d_next;
    logic [DIV_BITS-1:0] div_reg,   div_next;
    logic [CFG_W-1:0]    rem_reg,   rem_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [ADDR_W-1:0]   a_reg,     a_next;
    logic [ADDR_W-1:0]   b_reg,     b_next;
    logic                valid_reg, valid_next;
    logic [OUT_W-1:0]    index_reg, index_next;
    logic [OUT_W-1:0]    draw_reg,  draw_next;
    logic                exh_reg,   exh_next;

    logic [CFG_W-1:0]  eff;
    logic              exh_now;
    logic [CFG_W-1:0]  j_full;
    logic [ADDR_W-1:0] step_addr;
    logic [ADDR_W-1:0] j_addr;
    logic [CFG_W:0]    trial;
    logic [CFG_W:0]    diff;
    logic              ge;
    logic [ADDR_W-1:0] b_val;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [RAM_W-1:0]  ram_wdata;
    logic [RAM_W-1:0]  ram_rdata;

    rswr_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_POSITIONS)
    ) u_pool (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign eff       = (position_count > CFG_W'(MAX_CLIP)) ? CFG_W'(MAX_CLIP) : position_count;
    assign exh_now   = (step_reg >= sample_limit) || (step_reg >= eff);
    assign j_full    = step_reg + rem_reg;
    assign step_addr = ADDR_W'(step_reg);
    assign j_addr    = ADDR_W'(j_full);
    assign trial     = {rem_reg, div_reg[DIV_BITS-1]};
    assign diff      = trial - {1'b0, d_reg};
    assign ge        = (trial >= {1'b0, d_reg});
    assign b_val     = pool_value(ram_rdata, j_addr, epoch_reg);

    always_comb begin
        case (ctl.op)
            OP_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
            end
            OP_RDA: begin
                ram_we    = 1'b0;
                ram_addr  = step_addr;
                ram_wdata = '0;
            end
            OP_RDB: begin
                ram_we    = 1'b0;
                ram_addr  = j_addr;
                ram_wdata = '0;
            end
            OP_WRA: begin
                ram_we    = 1'b1;
                ram_addr  = step_addr;
                ram_wdata = {epoch_reg, b_val};
            end
            OP_WRB: begin
                ram_we    = 1'b1;
                ram_addr  = j_addr;
                ram_wdata = {epoch_reg, a_reg};
            end
            default: begin
                ram_we    = 1'b0;
                ram_addr  = step_addr;
                ram_wdata = '0;
            end
        endcase
    end

    always_comb begin
        gen_next   = gen_reg;
        step_next  = step_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        d_next     = d_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        valid_next = valid_reg && !m_ready;
        index_next = index_reg;
        draw_next  = draw_reg;
        exh_next   = exh_reg;
        case (ctl.op)
            OP_CLR: begin
                clr_next = clr_reg + 1'b1;
            end
            OP_ADV: begin
                gen_next = SEED_W'(gen_reg * LCG_MUL) + LCG_ADD;
                d_next   = eff - step_reg;
            end
            OP_DLD: begin
                div_next = gen_reg[SEED_W-1:1];
                rem_next = '0;
                cnt_next = CNT_W'(DIV_BITS - 1);
            end
            OP_DIV: begin
                div_next = {div_reg[DIV_BITS-2:0], 1'b0};
                rem_next = ge ? CFG_W'(diff) : CFG_W'(trial);
                cnt_next = cnt_reg - 1'b1;
            end
            OP_RDB: begin
                a_next = pool_value(ram_rdata, step_addr, epoch_reg);
            end
            OP_WRA: begin
                b_next = b_val;
            end
            OP_WRB: begin
                valid_next = 1'b1;
                index_next = OUT_W'(b_reg);
                draw_next  = OUT_W'(step_reg);
                exh_next   = 1'b0;
                step_next  = step_reg + 1'b1;
            end
            OP_EXH: begin
                valid_next = 1'b1;
                index_next = '0;
                draw_next  = OUT_W'(step_reg);
                exh_next   = 1'b1;
            end
            OP_RST: begin
                gen_next   = seed;
                step_next  = '0;
                epoch_next = (&epoch_reg) ? TAG_W'(1) : epoch_reg + 1'b1;
                valid_next = 1'b1;
                index_next = '0;
                draw_next  = '0;
                exh_next   = (sample_limit == '0) || (eff == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg   <= SEED_RESET;
            step_reg  <= '0;
            epoch_reg <= TAG_W'(1);
            clr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            gen_reg   <= gen_next;
            step_reg  <= step_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
            valid_reg <= valid_next;
        end
        d_reg     <= d_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        index_reg <= index_next;
        draw_reg  <= draw_next;
        exh_reg   <= exh_next;
    end

    assign sts.exhausted = exh_now;
    assign sts.div_last  = (cnt_reg == '0);
    assign sts.clr_last  = &clr_reg;
    assign sts.epoch_max = &epoch_reg;

    assign m_valid       = valid_reg;
    assign m_index       = index_reg;
    assign m_draw_number = draw_reg;
    assign m_exhausted   = exh_reg;

endmodule

// ===== hdl/random_sample_without_replacement_unit.sv =====
// ---------------------------------------------------------------------------
// random_sample_without_replacement_unit: distinct index sampler
// Draw: after accept, check, advance, divider load, the 31-step remainder loop, then pool reads and writes.
// No new request is taken until the unit is back in idle. A refused draw goes from the check to its result.
// Reset is synchronous; a pool tag clearing pass over all 65536 entries follows it, and every 255th restart.
// ---------------------------------------------------------------------------
`include "random_sample_without_replacement_unit_assert.svh"

module random_sample_without_replacement_unit import rswr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [SEED_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_index,
    output logic [OUT_W-1:0]     m_draw_number,
    output logic                 m_exhausted
);

    logic [CFG_W-1:0]  count_reg;
    logic [CFG_W-1:0]  limit_reg;
    logic [SEED_W-1:0] seed_reg;

    ctl_t ctl;
    sts_t sts;
    logic accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_RESET;
            limit_reg <= LIMIT_RESET;
            seed_reg  <= SEED_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_POSITION_COUNT: count_reg <= cfg_wr_data[CFG_W-1:0];
                REG_SAMPLE_LIMIT:   limit_reg <= cfg_wr_data[CFG_W-1:0];
                REG_SEED:           seed_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign s_ready = ctl.idle && (!m_valid || m_ready);
    assign accept  = s_valid && s_ready;

    rswr_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .restart(s_restart),
        .sts    (sts),
        .ctl    (ctl)
    );

    rswr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .position_count(count_reg),
        .sample_limit  (limit_reg),
        .seed          (seed_reg),
        .m_ready       (m_ready),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_index       (m_index),
        .m_draw_number (m_draw_number),
        .m_exhausted   (m_exhausted)
    );

    `RSWR_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready, "ready high right after accept")
    `RSWR_ASSERT_NOW(a_push_slot_free, (ctl.op == OP_WRB || ctl.op == OP_EXH || ctl.op == OP_RST), !m_valid, "result pushed into a full slot")
    `RSWR_ASSERT_NOW(a_exh_index_zero, m_valid && m_exhausted, m_index == '0, "refused draw with nonzero index")
    `RSWR_ASSERT_NOW(a_idle_no_op, ctl.idle, ctl.op == OP_NONE, "datapath op issued while waiting")

endmodule
